@@ hdl/ssag_pkg.sv @@
// Shared constants for the strip sub-block address generator.
// Used by ssag_mac, strip_subblock_address_generator and the testbench; no dependencies.
`timescale 1ns / 1ps

package ssag_pkg;

    // Offset, length and block size widths
    localparam int OFF_W   = 48;
    localparam int LEN_W   = 32;
    localparam int BS_W    = 16;

    // Multiplier digit width of the shared multiply-accumulate unit
    localparam int CHUNK_W = 16;

    // Stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 2 * OFF_W + LEN_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LENGTHS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_COUNTS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_POSITIONS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 3'd4;

    // Register reset values
    localparam logic [2:0]            RST_DIM_COUNT  = 3'd1;
    localparam logic [CFG_DATA_W-1:0] RST_PACKED_ONE = 64'h0001_0001_0001_0001;
    localparam logic [BS_W-1:0]       RST_BLOCK_SIZE = 16'd1;

    // Saturated run length
    localparam logic [LEN_W-1:0] LEN_SAT = '1;

endpackage

@@ hdl/ssag_div.sv @@
// Restoring divider, one quotient bit per cycle, used to size strip widths.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module ssag_div #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_left;
    logic             r_done;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_left <= CNT_W'(W);
            end else if (r_left != '0) begin
                r_rem  <= ge ? diff[W-1:0] : trial[W-1:0];
                r_quo  <= {r_quo[W-2:0], ge};
                r_left <= r_left - 1'b1;
                r_done <= (r_left == CNT_W'(1));
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ hdl/ssag_mac.sv @@
// Shared multiply-accumulate unit: acc + a * b modulo 2^48, one 16-bit digit
// of b per cycle. Depends on ssag_pkg.
`timescale 1ns / 1ps

module ssag_mac #(
    parameter int B_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ssag_pkg::OFF_W-1:0] i_a,
    input  logic [B_BITS-1:0]         i_b,
    input  logic [ssag_pkg::OFF_W-1:0] i_acc,
    output logic                      o_done,
    output logic [ssag_pkg::OFF_W-1:0] o_result
);

    localparam int NCH   = (B_BITS + ssag_pkg::CHUNK_W - 1) / ssag_pkg::CHUNK_W;
    localparam int BP_W  = NCH * ssag_pkg::CHUNK_W;
    localparam int CNT_W = $clog2(NCH + 1);
    localparam int PROD_W = ssag_pkg::OFF_W + ssag_pkg::CHUNK_W;

    logic [ssag_pkg::OFF_W-1:0] r_a;
    logic [BP_W-1:0]            r_b;
    logic [ssag_pkg::OFF_W-1:0] r_acc;
    logic [CNT_W-1:0]           r_left;
    logic                       r_done;

    logic [PROD_W-1:0]          prod;
    logic [ssag_pkg::OFF_W-1:0] n_acc;

    // One partial product per cycle, truncated to the offset width
    always_comb begin
        prod  = r_a * r_b[ssag_pkg::CHUNK_W-1:0];
        n_acc = r_acc + prod[ssag_pkg::OFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= BP_W'(i_b);
                r_acc  <= i_acc;
                r_left <= CNT_W'(NCH);
            end else if (r_left != '0) begin
                r_acc  <= n_acc;
                r_a    <= r_a << ssag_pkg::CHUNK_W;
                r_b    <= r_b >> ssag_pkg::CHUNK_W;
                r_left <= r_left - 1'b1;
                r_done <= (r_left == CNT_W'(1));
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

@@ hdl/strip_subblock_address_generator.sv @@
// Strip sub-block copy descriptor generator: sequencer, stride and offset state.
// Depends on ssag_pkg, ssag_div and ssag_mac.
// Requests are taken one at a time: the next is accepted only after the descriptor of the
//   last is loaded into the output register, which waits while that register still holds
//   an unread descriptor. Each run makes three passes through the shared multiply-accumulate
//   unit, then a carry walk over the outer dimensions.
//   The first run of a strip adds setup: a divide per dimension for the strip widths, a
//   stride product per dimension past the first, and two multiply passes per dimension
//   for the start offset.
// Reset (synchronous, active low): registers take their defaults, no strip in progress.
`timescale 1ns / 1ps

module strip_subblock_address_generator #(
    parameter int MAX_DIMS    = 4,
    parameter int EXTENT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [ssag_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ssag_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [0] direction
    // Descriptor stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [47:0] source_offset, [95:48] dest_offset, [127:96] run_length
    output logic [ssag_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int E     = EXTENT_BITS;
    localparam int NW    = $clog2(MAX_DIMS + 1);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int MB    = (E > ssag_pkg::BS_W) ? E : ssag_pkg::BS_W;
    localparam int OW    = ssag_pkg::OFF_W;
    localparam int LW    = ssag_pkg::LEN_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LDA,
        ST_POS,
        ST_OFS,
        ST_ANCH,
        ST_MUL_T,
        ST_MUL_B,
        ST_MUL_L,
        ST_WALK,
        ST_OUT
    } t_state;

    // Extract one packed extent field; fields past bit 63 read as zero
    function automatic logic [E-1:0] f_field(input logic [63:0] reg_v, input int unsigned d);
        logic [63:0] sh;
        int unsigned lo;
        lo = d * E;
        if (lo >= 64) begin
            sh = '0;
        end else begin
            sh = reg_v >> lo;
        end
        return sh[E-1:0];
    endfunction

    // Configuration registers
    logic [2:0]                         r_dim_count;
    logic [ssag_pkg::CFG_DATA_W-1:0]    r_edges;
    logic [ssag_pkg::CFG_DATA_W-1:0]    r_strips;
    logic [ssag_pkg::CFG_DATA_W-1:0]    r_positions;
    logic [ssag_pkg::BS_W-1:0]          r_block_size;

    // Sequencer and walk state
    t_state           r_state;
    logic             r_wait;
    logic [NW-1:0]    r_idx;
    logic             r_in_prog;
    logic             r_dir;
    logic             r_last;
    logic [E-1:0]     r_cnt  [MAX_DIMS];
    logic [E-1:0]     r_w    [MAX_DIMS];
    logic [OW-1:0]    r_lda  [MAX_DIMS];
    logic [OW-1:0]    r_anch [MAX_DIMS];
    logic [OW-1:0]    r_toff;
    logic [OW-1:0]    r_boff;
    logic [OW-1:0]    r_tmp;
    logic [OW-1:0]    r_res_t;
    logic [OW-1:0]    r_res_b;
    logic [LW-1:0]    r_res_len;

    // Output register
    logic             r_out_valid;
    logic [OW-1:0]    r_out_src;
    logic [OW-1:0]    r_out_dst;
    logic [LW-1:0]    r_out_len;
    logic             r_out_last;

    // Decoded fields and helpers
    logic [E-1:0]     edge_f  [MAX_DIMS];
    logic [E-1:0]     strip_f [MAX_DIMS];
    logic [E-1:0]     pos_f   [MAX_DIMS];
    logic [3:0]       dc_ext;
    logic [NW-1:0]    dims;
    logic [NW-1:0]    idx_inc;
    logic [NW-1:0]    idx_dec;
    logic [DW-1:0]    idx_cur;
    logic [DW-1:0]    idx_prev;
    logic [E:0]       cnt_inc;
    logic [OW-1:0]    n_toff;
    logic [LW-1:0]    len_sat;
    logic             out_free;

    // Shared unit hookup
    logic             div_start;
    logic             div_done;
    logic [E-1:0]     div_quo;
    logic             mac_start;
    logic             mac_done;
    logic [OW-1:0]    mac_a;
    logic [MB-1:0]    mac_b;
    logic [OW-1:0]    mac_acc;
    logic [OW-1:0]    mac_res;

    // Unpack extents and clamp the dimension count
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            edge_f[d]  = f_field(r_edges, d);
            strip_f[d] = f_field(r_strips, d);
            pos_f[d]   = f_field(r_positions, d);
        end
        dc_ext = {1'b0, r_dim_count};
        if (dc_ext == 4'd0) begin
            dims = NW'(1);
        end else if (dc_ext > 4'(MAX_DIMS)) begin
            dims = NW'(MAX_DIMS);
        end else begin
            dims = NW'(dc_ext);
        end
        idx_inc  = r_idx + 1'b1;
        idx_dec  = r_idx - 1'b1;
        idx_cur  = r_idx[DW-1:0];
        idx_prev = idx_dec[DW-1:0];
        cnt_inc  = {1'b0, r_cnt[idx_cur]} + 1'b1;
        n_toff   = r_toff + r_lda[idx_cur];
        len_sat  = (mac_res[OW-1:LW] != '0) ? ssag_pkg::LEN_SAT : mac_res[LW-1:0];
        out_free = !r_out_valid || m_axis_tready;
    end

    // Select operands for the shared multiply-accumulate unit
    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_acc = '0;
        case (r_state)
            ST_LDA: begin
                mac_a = r_lda[idx_prev];
                mac_b = MB'(edge_f[idx_prev]);
            end
            ST_POS: begin
                mac_a = r_lda[idx_cur];
                mac_b = MB'(pos_f[idx_cur]);
            end
            ST_OFS: begin
                mac_a   = r_tmp;
                mac_b   = MB'(r_w[idx_cur]);
                mac_acc = r_toff;
            end
            ST_MUL_T: begin
                mac_a = r_toff;
                mac_b = MB'(r_block_size);
            end
            ST_MUL_B: begin
                mac_a = r_boff;
                mac_b = MB'(r_block_size);
            end
            ST_MUL_L: begin
                mac_a = OW'(r_w[0]);
                mac_b = MB'(r_block_size);
            end
            default: begin
                mac_a = '0;
            end
        endcase
        // No stride product once every dimension has one
        mac_start = !r_wait && ((r_state == ST_LDA && r_idx < dims) ||
                    r_state == ST_POS || r_state == ST_OFS || r_state == ST_MUL_T ||
                    r_state == ST_MUL_B || r_state == ST_MUL_L);
        div_start = !r_wait && (r_state == ST_DIV);
    end

    ssag_div #(
        .W (E)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (edge_f[idx_cur]),
        .i_divisor  (strip_f[idx_cur]),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    ssag_mac #(
        .B_BITS (MB)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_a      (mac_a),
        .i_b      (mac_b),
        .i_acc    (mac_acc),
        .o_done   (mac_done),
        .o_result (mac_res)
    );

    // Sequencer, strip state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wait       <= 1'b0;
            r_idx        <= '0;
            r_in_prog    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_toff       <= '0;
            r_boff       <= '0;
            r_dim_count  <= ssag_pkg::RST_DIM_COUNT;
            r_edges      <= ssag_pkg::RST_PACKED_ONE;
            r_strips     <= ssag_pkg::RST_PACKED_ONE;
            r_positions  <= '0;
            r_block_size <= ssag_pkg::RST_BLOCK_SIZE;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_cnt[d] <= '0;
            end
        end else begin
            // Drop the descriptor once taken
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Hold the unit busy flag from issue to done
            if (div_start || mac_start) begin
                r_wait <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_dir <= s_axis_tdata[0];
                        r_idx <= '0;
                        r_state <= r_in_prog ? ST_MUL_T : ST_DIV;
                    end
                end
                // Strip widths, one dimension per divide
                ST_DIV: begin
                    if (div_done) begin
                        r_wait <= 1'b0;
                        r_w[idx_cur] <= (strip_f[idx_cur] == '0) ? '0 : div_quo;
                        if (idx_inc == dims) begin
                            r_lda[0] <= OW'(1);
                            r_idx    <= NW'(1);
                            r_state  <= ST_LDA;
                        end else begin
                            r_idx <= idx_inc;
                        end
                    end
                end
                // Column-major strides
                ST_LDA: begin
                    if (r_idx >= dims) begin
                        r_idx   <= '0;
                        r_toff  <= '0;
                        r_state <= ST_POS;
                    end else if (mac_done) begin
                        r_wait <= 1'b0;
                        r_lda[idx_cur] <= mac_res;
                        r_idx <= idx_inc;
                    end
                end
                // Start offset: sum of position * width * stride
                ST_POS: begin
                    if (mac_done) begin
                        r_wait  <= 1'b0;
                        r_tmp   <= mac_res;
                        r_state <= ST_OFS;
                    end
                end
                ST_OFS: begin
                    if (mac_done) begin
                        r_wait <= 1'b0;
                        r_toff <= mac_res;
                        if (idx_inc == dims) begin
                            r_state <= ST_ANCH;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= ST_POS;
                        end
                    end
                end
                // Seed the walk: every dimension returns to the start offset
                ST_ANCH: begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        r_anch[d] <= r_toff;
                        r_cnt[d]  <= '0;
                    end
                    r_boff    <= '0;
                    r_in_prog <= 1'b1;
                    r_state   <= ST_MUL_T;
                end
                // Scale offsets and length by the block size
                ST_MUL_T: begin
                    if (mac_done) begin
                        r_wait  <= 1'b0;
                        r_res_t <= mac_res;
                        r_state <= ST_MUL_B;
                    end
                end
                ST_MUL_B: begin
                    if (mac_done) begin
                        r_wait  <= 1'b0;
                        r_res_b <= mac_res;
                        r_state <= ST_MUL_L;
                    end
                end
                ST_MUL_L: begin
                    if (mac_done) begin
                        r_wait    <= 1'b0;
                        r_res_len <= len_sat;
                        r_boff    <= r_boff + OW'(r_w[0]);
                        r_idx     <= NW'(1);
                        r_state   <= ST_WALK;
                    end
                end
                // Carry walk, one dimension per cycle
                ST_WALK: begin
                    if (r_idx >= dims) begin
                        r_last    <= 1'b1;
                        r_in_prog <= 1'b0;
                        r_state   <= ST_OUT;
                    end else if (cnt_inc < {1'b0, r_w[idx_cur]}) begin
                        r_cnt[idx_cur] <= cnt_inc[E-1:0];
                        r_toff <= n_toff;
                        for (int d = 0; d < MAX_DIMS; d++) begin
                            if (NW'(d) < r_idx) begin
                                r_anch[d] <= n_toff;
                            end
                        end
                        r_last  <= 1'b0;
                        r_state <= ST_OUT;
                    end else begin
                        r_cnt[idx_cur] <= '0;
                        r_toff <= r_anch[idx_cur];
                        r_idx  <= idx_inc;
                    end
                end
                // Load the descriptor when the output register is free
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_src   <= r_dir ? r_res_b : r_res_t;
                        r_out_dst   <= r_dir ? r_res_t : r_res_b;
                        r_out_len   <= r_res_len;
                        r_out_last  <= r_last;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // A write to any defined register abandons a strip in progress
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ssag_pkg::CFG_DIM_COUNT: begin
                        r_dim_count <= i_cfg_data[2:0];
                        r_in_prog   <= 1'b0;
                    end
                    ssag_pkg::CFG_EDGE_LENGTHS: begin
                        r_edges   <= i_cfg_data;
                        r_in_prog <= 1'b0;
                    end
                    ssag_pkg::CFG_STRIP_COUNTS: begin
                        r_strips  <= i_cfg_data;
                        r_in_prog <= 1'b0;
                    end
                    ssag_pkg::CFG_STRIP_POSITIONS: begin
                        r_positions <= i_cfg_data;
                        r_in_prog   <= 1'b0;
                    end
                    ssag_pkg::CFG_BLOCK_SIZE: begin
                        r_block_size <= i_cfg_data[ssag_pkg::BS_W-1:0];
                        r_in_prog    <= 1'b0;
                    end
                    default: begin
                        r_in_prog <= r_in_prog;
                    end
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_dst, r_out_src};
    assign m_axis_tlast  = r_out_last;

    // A multiply result only arrives in a state that issued one
    a_mac_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> r_wait && (r_state == ST_LDA || r_state == ST_POS ||
        r_state == ST_OFS || r_state == ST_MUL_T || r_state == ST_MUL_B ||
        r_state == ST_MUL_L))
        else $error("multiply done outside a multiply step");

    // A divide result only arrives while sizing strip widths
    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_wait && (r_state == ST_DIV))
        else $error("divide done outside width setup");

    // The carry walk never visits dimension 0
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_idx != '0))
        else $error("carry walk on dimension 0");

endmodule

@@ verif/tb.sv @@
// Testbench for strip_subblock_address_generator: directed and random copy requests under random
// flow control and register settings; an in-order predictor checks every descriptor.
// Depends on ssag_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

    localparam int          DIM_SLOTS    = 4;
    localparam int          FIELD_W      = 16;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [63:0] MASK48       = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] LEN_MAX      = 64'h0000_0000_FFFF_FFFF;

    localparam int OFF_W       = ssag_pkg::OFF_W;
    localparam int LEN_W       = ssag_pkg::LEN_W;
    localparam int IDX_W       = ssag_pkg::CFG_IDX_W;
    localparam int OUT_TDATA_W = ssag_pkg::OUT_TDATA_W;

    // Indexes past the register list: writes there must change nothing
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = ssag_pkg::CFG_BLOCK_SIZE + 1'b1;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    typedef struct {
        logic [OFF_W-1:0] src;
        logic [OFF_W-1:0] dst;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_descr;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]                    i_cfg_index   = '0;
    logic [ssag_pkg::CFG_DATA_W-1:0]     i_cfg_data    = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [ssag_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;   // [0] direction
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [47:0] source_offset, [95:48] dest_offset, [127:96] run_length
    logic [OUT_TDATA_W-1:0]              m_axis_tdata;
    logic                                m_axis_tlast;

    strip_subblock_address_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Predictor copy of the registers and the strip walk
    logic [2:0]   cfg_dims;
    logic [63:0]  cfg_edges;
    logic [63:0]  cfg_strips;
    logic [63:0]  cfg_pos;
    logic [15:0]  cfg_bs;
    logic [63:0]  pos_cnt [DIM_SLOTS];
    logic [63:0]  run_tensor;
    logic [63:0]  run_buffer;
    bit           strip_active;

    t_descr       pending_descr [$];
    int           err_count     = 0;
    int           cycle_count   = 0;
    int           burst_left    = 0;
    bit           sender_steady = 1'b0;
    int           hold_tag      = 0;
    int           hold_len      = 0;

    function automatic void model_reset();
        int i;
        cfg_dims   = ssag_pkg::RST_DIM_COUNT;
        cfg_edges  = ssag_pkg::RST_PACKED_ONE;
        cfg_strips = ssag_pkg::RST_PACKED_ONE;
        cfg_pos    = '0;
        cfg_bs     = ssag_pkg::RST_BLOCK_SIZE;
        for (i = 0; i < DIM_SLOTS; i++) pos_cnt[i] = '0;
        run_tensor   = '0;
        run_buffer   = '0;
        strip_active = 1'b0;
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
        bit known;
        known = 1'b1;
        case (idx)
            ssag_pkg::CFG_DIM_COUNT:       cfg_dims   = val[2:0];
            ssag_pkg::CFG_EDGE_LENGTHS:    cfg_edges  = val;
            ssag_pkg::CFG_STRIP_COUNTS:    cfg_strips = val;
            ssag_pkg::CFG_STRIP_POSITIONS: cfg_pos    = val;
            ssag_pkg::CFG_BLOCK_SIZE:      cfg_bs     = val[15:0];
            default:                       known      = 1'b0;
        endcase
        // Any real register write drops the strip in progress
        if (known) strip_active = 1'b0;
    endfunction

    function automatic int dims_in_use();
        if (cfg_dims == 3'd0) return 1;
        if (cfg_dims > 3'(DIM_SLOTS)) return DIM_SLOTS;
        return int'(cfg_dims);
    endfunction

    function automatic logic [63:0] strip_width(int i);
        logic [63:0] e, s;
        e = {48'd0, cfg_edges[FIELD_W*i +: FIELD_W]};
        s = {48'd0, cfg_strips[FIELD_W*i +: FIELD_W]};
        return (s == 0) ? 64'd0 : e / s;
    endfunction

    // Runs in one full strip: product of the outer widths, zero width counts as one
    function automatic logic [63:0] strip_runs();
        logic [63:0] runs, w;
        int i;
        runs = 64'd1;
        for (i = 1; i < dims_in_use(); i++) begin
            w = strip_width(i);
            if (w > 1) runs = runs * w;
        end
        return runs;
    endfunction

    // Work out the next descriptor of the strip and advance the walk
    function automatic t_descr next_descriptor(bit dir);
        logic [63:0] lda [DIM_SLOTS];
        logic [63:0] stride, start, w, c, w0, len, toff, boff;
        int          n, i;
        bit          fin;
        t_descr      d;
        n = dims_in_use();
        stride = 64'd1;
        for (i = 0; i < DIM_SLOTS; i++) lda[i] = '0;
        for (i = 0; i < n; i++) begin
            lda[i] = stride;
            stride = (stride * {48'd0, cfg_edges[FIELD_W*i +: FIELD_W]}) & MASK48;
        end
        // Start of a fresh strip: corner offset from the strip positions
        if (!strip_active) begin
            run_tensor = '0;
            for (i = 0; i < DIM_SLOTS; i++) pos_cnt[i] = '0;
            for (i = 0; i < n; i++) begin
                start = {48'd0, cfg_pos[FIELD_W*i +: FIELD_W]} * strip_width(i);
                run_tensor = (run_tensor + start * lda[i]) & MASK48;
            end
            run_buffer   = '0;
            strip_active = 1'b1;
        end
        w0   = strip_width(0);
        toff = (run_tensor * {48'd0, cfg_bs}) & MASK48;
        boff = (run_buffer * {48'd0, cfg_bs}) & MASK48;
        len  = w0 * {48'd0, cfg_bs};
        if (len > LEN_MAX) len = LEN_MAX;
        run_buffer = (run_buffer + w0) & MASK48;
        // Carry walk over the outer dimensions
        fin = 1'b1;
        for (i = 1; i < n; i++) begin
            w = strip_width(i);
            c = pos_cnt[i];
            if (c + 64'd1 < w) begin
                pos_cnt[i] = c + 64'd1;
                run_tensor = (run_tensor + lda[i]) & MASK48;
                fin = 1'b0;
                break;
            end
            run_tensor = (run_tensor - c * lda[i]) & MASK48;
            pos_cnt[i] = '0;
        end
        if (fin) strip_active = 1'b0;
        d.src  = dir ? boff[OFF_W-1:0] : toff[OFF_W-1:0];
        d.dst  = dir ? toff[OFF_W-1:0] : boff[OFF_W-1:0];
        d.len  = len[LEN_W-1:0];
        d.last = fin;
        return d;
    endfunction

    function automatic void flag_field(string fname, logic [63:0] want, logic [63:0] got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch in %s: expected %h, got %h", fname, want, got);
    endfunction

    // Check each accepted descriptor against the oldest prediction
    always @(posedge i_clk) begin
        t_descr want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_descr.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("descriptor with no request pending: %h", m_axis_tdata);
            end else begin
                want = pending_descr.pop_front();
                if (m_axis_tdata[OFF_W-1:0] !== want.src)
                    flag_field("source_offset", 64'(want.src),
                               64'(m_axis_tdata[OFF_W-1:0]));
                if (m_axis_tdata[2*OFF_W-1:OFF_W] !== want.dst)
                    flag_field("dest_offset", 64'(want.dst),
                               64'(m_axis_tdata[2*OFF_W-1:OFF_W]));
                if (m_axis_tdata[OUT_TDATA_W-1:2*OFF_W] !== want.len)
                    flag_field("run_length", 64'(want.len),
                               64'(m_axis_tdata[OUT_TDATA_W-1:2*OFF_W]));
                if (m_axis_tlast !== want.last)
                    flag_field("last", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL strip_subblock_address_generator");
            $finish;
        end
    end

    // Descriptor side: stall pattern that changes mode, plus long hold-offs on request
    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       hold_seen    = 0;
    int       stall_left   = 0;

    always @(negedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen     <= hold_tag;
            stall_left    <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(20, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:     m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_axis_tready <= (cycle_count % 4 == 0);
                default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Offer one request in bursts with random gaps; predict it on acceptance
    task automatic send_request(input bit dir);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            if (!sender_steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ssag_pkg::IN_TDATA_W'(dir);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_descr.push_back(next_descriptor(dir));
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted descriptor has come out
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_descr.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Reset settings: one-element runs at offset zero, every run closes the strip
    task automatic test_reset_state();
        int k;
        for (k = 0; k < 4; k++) send_request(k[0]);
    endtask

    task automatic test_special_cases();
        int k;
        // Two dimensions: 4x6 tensor in 2x3 strips, strip (1,2), blocks of 3; wraps once
        write_reg(ssag_pkg::CFG_DIM_COUNT, 64'd2);
        write_reg(ssag_pkg::CFG_EDGE_LENGTHS, {16'd1, 16'd1, 16'd6, 16'd4});
        write_reg(ssag_pkg::CFG_STRIP_COUNTS, {16'd1, 16'd1, 16'd3, 16'd2});
        write_reg(ssag_pkg::CFG_STRIP_POSITIONS, {16'd0, 16'd0, 16'd2, 16'd1});
        write_reg(ssag_pkg::CFG_BLOCK_SIZE, 64'd3);
        for (k = 0; k < 3; k++) send_request(k[0]);
        // Zero strip count in dimension 0 gives zero-length runs
        write_reg(ssag_pkg::CFG_STRIP_COUNTS, {16'd1, 16'd1, 16'd3, 16'd0});
        send_request(1'b0);
        // Zero strip count in an outer dimension closes the strip on every run
        write_reg(ssag_pkg::CFG_STRIP_COUNTS, {16'd1, 16'd1, 16'd0, 16'd2});
        send_request(1'b1);
        send_request(1'b0);
        // Zero block size zeroes all offsets and lengths
        write_reg(ssag_pkg::CFG_STRIP_COUNTS, {16'd1, 16'd1, 16'd3, 16'd2});
        write_reg(ssag_pkg::CFG_BLOCK_SIZE, 64'd0);
        send_request(1'b0);
        send_request(1'b1);
        // Dimension count zero reads as one
        write_reg(ssag_pkg::CFG_BLOCK_SIZE, 64'd5);
        write_reg(ssag_pkg::CFG_DIM_COUNT, 64'd0);
        send_request(1'b1);
        send_request(1'b0);
        // Count above the maximum saturates; full-range fields wrap the offsets at 48 bits
        write_reg(ssag_pkg::CFG_DIM_COUNT, 64'd7);
        write_reg(ssag_pkg::CFG_EDGE_LENGTHS, '1);
        write_reg(ssag_pkg::CFG_STRIP_COUNTS, {4{16'd1}});
        write_reg(ssag_pkg::CFG_STRIP_POSITIONS, '1);
        write_reg(ssag_pkg::CFG_BLOCK_SIZE, 64'hFFFF);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Writes past the register list keep the strip going; a real write restarts it
    task automatic test_spare_registers();
        write_reg(ssag_pkg::CFG_DIM_COUNT, 64'd3);
        write_reg(ssag_pkg::CFG_EDGE_LENGTHS, {16'd1, 16'd3, 16'd3, 16'd5});
        write_reg(ssag_pkg::CFG_STRIP_COUNTS, {4{16'd1}});
        write_reg(ssag_pkg::CFG_STRIP_POSITIONS, '0);
        write_reg(ssag_pkg::CFG_BLOCK_SIZE, 64'd2);
        send_request(1'b0);
        send_request(1'b1);
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
        send_request(1'b0);
        send_request(1'b1);
        write_reg(ssag_pkg::CFG_BLOCK_SIZE, 64'd2);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    task automatic test_backpressure();
        int k;
        write_reg(ssag_pkg::CFG_DIM_COUNT, 64'd3);
        write_reg(ssag_pkg::CFG_EDGE_LENGTHS, {16'd1, 16'd4, 16'd5, 16'd8});
        write_reg(ssag_pkg::CFG_STRIP_COUNTS, {16'd1, 16'd2, 16'd1, 16'd2});
        write_reg(ssag_pkg::CFG_STRIP_POSITIONS, {16'd0, 16'd1, 16'd0, 16'd1});
        write_reg(ssag_pkg::CFG_BLOCK_SIZE, 64'd4);
        // Hold the descriptor side while requests keep coming
        hold_len = HOLD_CYCLES;
        hold_tag++;
        sender_steady = 1'b1;
        for (k = 0; k < 16; k++) send_request(1'($urandom_range(0, 1)));
        sender_steady = 1'b0;
        // Pause until everything is out, then resume mid-strip
        wait_for_drain();
        for (k = 0; k < 10; k++) send_request(1'($urandom_range(0, 1)));
    endtask

    // Phases of random settings: mostly whole small strips, some noise, some resumes
    task automatic test_random_strips();
        logic [15:0] e [DIM_SLOTS];
        logic [15:0] s [DIM_SLOTS];
        logic [15:0] p [DIM_SLOTS];
        logic [15:0] bs;
        logic [63:0] runs;
        int          sent, n_items, k, pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // Continue the current strip untouched
                n_items = $urandom_range(1, 12);
            end else if (pick == 1) begin
                // Fully random register contents
                write_reg(ssag_pkg::CFG_DIM_COUNT, {$urandom, $urandom});
                write_reg(ssag_pkg::CFG_EDGE_LENGTHS, {$urandom, $urandom});
                write_reg(ssag_pkg::CFG_STRIP_COUNTS, {$urandom, $urandom});
                write_reg(ssag_pkg::CFG_STRIP_POSITIONS, {$urandom, $urandom});
                write_reg(ssag_pkg::CFG_BLOCK_SIZE, {$urandom, $urandom});
                n_items = $urandom_range(2, 8);
            end else begin
                for (k = 0; k < DIM_SLOTS; k++) begin
                    if (k == 0)
                        e[k] = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(1, 24));
                    else
                        e[k] = ($urandom_range(0, 15) == 0) ? 16'd0
                                                            : 16'($urandom_range(1, 6));
                    s[k] = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
                    p[k] = 16'($urandom_range(0, s[k]));
                end
                case ($urandom_range(0, 9))
                    0:       bs = 16'd0;
                    1:       bs = 16'hFFFF;
                    2:       bs = 16'($urandom);
                    default: bs = 16'($urandom_range(1, 8));
                endcase
                if ($urandom_range(0, 9) == 0)
                    write_reg(ssag_pkg::CFG_DIM_COUNT, 64'($urandom_range(0, 7)));
                else
                    write_reg(ssag_pkg::CFG_DIM_COUNT, 64'($urandom_range(1, 4)));
                write_reg(ssag_pkg::CFG_EDGE_LENGTHS, {e[3], e[2], e[1], e[0]});
                write_reg(ssag_pkg::CFG_STRIP_COUNTS, {s[3], s[2], s[1], s[0]});
                write_reg(ssag_pkg::CFG_STRIP_POSITIONS, {p[3], p[2], p[1], p[0]});
                write_reg(ssag_pkg::CFG_BLOCK_SIZE, {48'd0, bs});
                runs = strip_runs();
                if (runs > 24)
                    n_items = $urandom_range(4, 48);
                else
                    n_items = int'(runs) * $urandom_range(1, 2) + $urandom_range(0, 2);
                // Sometimes leave the strip half done
                if ($urandom_range(0, 4) == 0) n_items = $urandom_range(1, n_items);
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          {$urandom, $urandom});
            for (k = 0; k < n_items; k++) send_request(1'($urandom_range(0, 1)));
            sent += n_items;
        end
    endtask

    initial begin
        model_reset();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_state();
        test_special_cases();
        test_spare_registers();
        test_backpressure();
        test_random_strips();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_descr.size() == 0)
            $display("PASS strip_subblock_address_generator");
        else
            $display("FAIL strip_subblock_address_generator");
        $finish;
    end

endmodule

@@ strip_subblock_address_generator.f @@
hdl/ssag_pkg.sv
hdl/ssag_div.sv
hdl/ssag_mac.sv
hdl/strip_subblock_address_generator.sv
verif/tb.sv
